// ===== src/obrf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Overwriting byte ring FIFO package
// Sizes, field widths, request codes and small helper functions shared by the
// ring FIFO, its checker and the testbench.
// ----------------------------------------------------------------------------
package obrf_pkg;

  localparam int DEPTH     = 256;
  localparam int MAX_BURST = 64;

  localparam int ADDR_W  = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int REM_W   = $clog2(MAX_BURST + 1);
  localparam int BYTE_W  = 8;
  localparam int BURST_W = 7;
  localparam int LEVEL_W = 8;
  localparam int OVF_W   = 32;

  // Request codes carried on req_type.
  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } req_kind_t;

  // Slot index after p, wrapping at the end of the ring.
  function automatic logic [ADDR_W-1:0] next_ptr(input logic [ADDR_W-1:0] p);
    logic [ADDR_W-1:0] r;
    if (p == ADDR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  // Bytes one read burst takes: the request length saturated to the
  // largest burst, and no more than the bytes held.
  function automatic logic [REM_W-1:0] take_len(input logic [BURST_W-1:0] bl,
                                                input logic [ADDR_W-1:0]  cnt);
    int b;
    int c;
    b = int'(bl);
    c = int'(cnt);
    if (b > MAX_BURST) begin
      b = MAX_BURST;
    end
    if (c < b) begin
      b = c;
    end
    return REM_W'(b);
  endfunction

endpackage
`default_nettype wire

// ===== src/overwriting_byte_ring_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Overwriting byte ring FIFO
// Ring of DEPTH byte slots in one synchronous memory; writes overwrite the
// oldest byte when full, reads return bursts of bytes with status.
// ----------------------------------------------------------------------------
// The FIFO holds at most DEPTH-1 bytes in a single-port-per-direction memory
// with a registered read. A write request is accepted every cycle while no
// read burst is in flight; when the FIFO is full it drops the oldest byte
// and bumps the 32-bit wrapping overflow counter. A read request for n bytes
// (n is the burst length saturated to MAX_BURST and limited to the fill
// level) issues one memory read per cycle while its results are not
// stalled, so it delivers n results; the next request is taken once the
// last read has been issued and its data has moved into the output
// register. A read with nothing to take gives a single result marked empty
// and last in the cycle after acceptance. The result channel has its own
// output register, so a stalled result blocks writes only while read data
// still waits behind it. Every result carries the fill level and free space
// after that byte was removed and the overflow count. The memory is never
// cleared; only slots inside the filled region are read.
// ----------------------------------------------------------------------------
module overwriting_byte_ring_fifo
  import obrf_pkg::*;
(
  input  wire                clk,
  input  wire                rst,
  input  wire                req_valid,
  output logic               req_stall,
  input  wire                req_type,
  input  wire  [BYTE_W-1:0]  data_byte,
  input  wire  [BURST_W-1:0] burst_length,
  output logic               rsp_valid,
  input  wire                rsp_stall,
  output logic [BYTE_W-1:0]  read_byte,
  output logic               last_of_burst,
  output logic               was_empty,
  output logic [LEVEL_W-1:0] fill_level,
  output logic [LEVEL_W-1:0] space_left,
  output logic [OVF_W-1:0]   overflow_count
);

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] head;
  logic [ADDR_W-1:0] tail;
  logic [ADDR_W-1:0] cnt;
  logic [OVF_W-1:0]  dropped;
  logic [REM_W-1:0]  remaining;

  // Read data in flight between the memory and the output register.
  logic              pend;
  logic              pend_last;
  logic [ADDR_W-1:0] pend_fill;
  logic [BYTE_W-1:0] rd_data;

  logic [BYTE_W-1:0] mem [DEPTH];

  logic              req_fire;
  logic              wr_fire;
  logic              rd_fire;
  logic              rsp_free;
  logic              load;
  logic              issue;
  logic [REM_W-1:0]  take;
  logic              full;

  // A read is held back while the output register is stuck, so an empty
  // result always finds room; writes only wait for a burst in flight.
  assign req_stall = (state != ST_IDLE) || pend ||
                     ((req_type != REQ_WRITE) && rsp_valid && rsp_stall);
  assign req_fire  = req_valid && !req_stall;
  assign wr_fire   = req_fire && (req_type == REQ_WRITE);
  assign rd_fire   = req_fire && (req_type != REQ_WRITE);

  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign load      = pend && rsp_free;
  assign issue     = (state == ST_BURST) && (!pend || load);

  assign take      = take_len(burst_length, cnt);
  assign full      = (cnt == ADDR_W'(DEPTH - 1));

  // Byte memory: one write port at the head, one registered read at the tail.
  // Writes happen only in idle and reads only during a burst.
  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem[head] <= data_byte;
    end
    if (issue) begin
      rd_data <= mem[tail];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= '0;
      cnt       <= '0;
      dropped   <= '0;
      remaining <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // Output register: take read data, load an empty result, or drain.
      if (load) begin
        rsp_valid      <= 1'b1;
        read_byte      <= rd_data;
        last_of_burst  <= pend_last;
        was_empty      <= 1'b0;
        fill_level     <= LEVEL_W'(32'(pend_fill));
        space_left     <= LEVEL_W'(32'(ADDR_W'(DEPTH - 1) - pend_fill));
        overflow_count <= dropped;
      end else if (rd_fire && (take == '0)) begin
        rsp_valid      <= 1'b1;
        read_byte      <= '0;
        last_of_burst  <= 1'b1;
        was_empty      <= 1'b1;
        fill_level     <= LEVEL_W'(32'(cnt));
        space_left     <= LEVEL_W'(32'(ADDR_W'(DEPTH - 1) - cnt));
        overflow_count <= dropped;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      if (issue) begin
        pend <= 1'b1;
      end else if (load) begin
        pend <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (wr_fire) begin
            head <= next_ptr(head);
            if (full) begin
              tail    <= next_ptr(tail);
              dropped <= dropped + 1'b1;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end else if (rd_fire && (take != '0)) begin
            remaining <= take;
            state     <= ST_BURST;
          end
        end
        ST_BURST: begin
          if (issue) begin
            tail      <= next_ptr(tail);
            cnt       <= cnt - 1'b1;
            pend_fill <= cnt - 1'b1;
            pend_last <= (remaining == REM_W'(1));
            remaining <= remaining - 1'b1;
            if (remaining == REM_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/obrf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Overwriting byte ring FIFO checker
// Port-level assertions on the ring FIFO, attached by a bind.
// ----------------------------------------------------------------------------
module obrf_checker
  import obrf_pkg::*;
(
  input wire                clk,
  input wire                rst,
  input wire                req_stall,
  input wire                rsp_valid,
  input wire                rsp_stall,
  input wire [BYTE_W-1:0]   read_byte,
  input wire                last_of_burst,
  input wire                was_empty,
  input wire [LEVEL_W-1:0]  fill_level,
  input wire [LEVEL_W-1:0]  space_left,
  input wire [OVF_W-1:0]    overflow_count
);

  // No result is shown in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  // A stalled result holds its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(read_byte) &&
      $stable(last_of_burst) && $stable(fill_level) && $stable(overflow_count))
    else $error("stalled result changed");

  // Fill level and free space always add up to the ring capacity.
  a_level_sum: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> LEVEL_W'(fill_level + space_left) == LEVEL_W'(DEPTH - 1))
    else $error("fill level and free space disagree");

  // An empty read gives one zero byte that closes the burst.
  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && was_empty |-> last_of_burst && (read_byte == '0))
    else $error("malformed empty result");

  // While a burst still has results to come, no new request is taken.
  a_burst_blocks: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !last_of_burst |-> req_stall)
    else $error("request accepted in the middle of a burst");

endmodule

bind overwriting_byte_ring_fifo obrf_checker u_obrf_checker (
  .clk            (clk),
  .rst            (rst),
  .req_stall      (req_stall),
  .rsp_valid      (rsp_valid),
  .rsp_stall      (rsp_stall),
  .read_byte      (read_byte),
  .last_of_burst  (last_of_burst),
  .was_empty      (was_empty),
  .fill_level     (fill_level),
  .space_left     (space_left),
  .overflow_count (overflow_count)
);
`default_nettype wire

// ===== dv/overwriting_byte_ring_fifo_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overwriting byte ring FIFO testbench
// Drives write and read-burst requests into the ring FIFO and checks every
// response against a cycle-free model of the ring, under random idling on
// both channels and one long response hold-off.
// ----------------------------------------------------------------------------
module overwriting_byte_ring_fifo_tb;
  import obrf_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RST_CYCLES   = 12;
  localparam int DRAIN_CYCLES = 20;
  // The limit lies far above what a correct run needs, even in the slowest
  // case of full bursts each waiting out long response stalls.
  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 350;

  // One expected response, field for field as the block reports it.
  typedef struct {
    logic [BYTE_W-1:0]  data;
    logic               last;
    logic               empty;
    logic [LEVEL_W-1:0] fill;
    logic [LEVEL_W-1:0] room;
    logic [OVF_W-1:0]   dropped;
  } fifo_rsp_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic               req_type = REQ_WRITE;
  logic [BYTE_W-1:0]  data_byte = '0;
  logic [BURST_W-1:0] burst_length = BURST_W'(1);
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic [BYTE_W-1:0]  read_byte;
  logic               last_of_burst;
  logic               was_empty;
  logic [LEVEL_W-1:0] fill_level;
  logic [LEVEL_W-1:0] space_left;
  logic [OVF_W-1:0]   overflow_count;

  // Shadow of the ring: slot contents, head and tail, and the drop counter.
  logic [BYTE_W-1:0] ring_bytes [DEPTH];
  int unsigned       ring_head = 0;
  int unsigned       ring_tail = 0;
  logic [OVF_W-1:0]  ring_dropped = '0;
  fifo_rsp_t         rsp_expect_q [$];

  // Idle rates in percent for the request sender and the response receiver.
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;

  // Long hold-off: the test bumps hold_seq, the receiver loads its own count.
  int hold_seq  = 0;
  int hold_len  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int mismatches   = 0;
  int rsp_checked  = 0;
  int empty_seen   = 0;
  int writes_sent  = 0;
  int reads_sent   = 0;
  int overwrites   = 0;
  int cycle_count  = 0;

  overwriting_byte_ring_fifo i_dut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req_type       (req_type),
    .data_byte      (data_byte),
    .burst_length   (burst_length),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .read_byte      (read_byte),
    .last_of_burst  (last_of_burst),
    .was_empty      (was_empty),
    .fill_level     (fill_level),
    .space_left     (space_left),
    .overflow_count (overflow_count)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Run guard: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Ring model
  // --------------------------------------------------------------------------

  // Bytes currently held between tail and head.
  function automatic int unsigned ring_held();
    return (ring_head + DEPTH - ring_tail) % DEPTH;
  endfunction

  function automatic void push_rsp(input logic [BYTE_W-1:0] d, input logic last,
                                   input logic empty);
    fifo_rsp_t r;
    r.data    = d;
    r.last    = last;
    r.empty   = empty;
    r.fill    = LEVEL_W'(ring_held());
    r.room    = LEVEL_W'(DEPTH - 1 - ring_held());
    r.dropped = ring_dropped;
    rsp_expect_q.push_back(r);
  endfunction

  // Applies one accepted request to the model and queues the responses it
  // must produce. A write never produces a response. A read takes the burst
  // length clipped to the largest burst and to the fill level; when that is
  // zero (empty ring, or a zero burst length) it yields one empty response.
  function automatic void predict_request(input req_kind_t kind,
                                          input logic [BYTE_W-1:0] d,
                                          input logic [BURST_W-1:0] bl);
    int take;
    if (kind == REQ_WRITE) begin
      // Full ring: the oldest byte is dropped to make room.
      if (ring_held() >= DEPTH - 1) begin
        ring_tail    = (ring_tail + 1) % DEPTH;
        ring_dropped = ring_dropped + 1'b1;
        overwrites++;
      end
      ring_bytes[ring_head] = d;
      ring_head = (ring_head + 1) % DEPTH;
    end else begin
      take = (int'(bl) > MAX_BURST) ? MAX_BURST : int'(bl);
      if (take > int'(ring_held())) begin
        take = int'(ring_held());
      end
      if (take == 0) begin
        push_rsp('0, 1'b1, 1'b1);
      end else begin
        for (int i = 0; i < take; i++) begin
          // Status fields reflect the ring after this byte has left it.
          ring_tail = (ring_tail + 1) % DEPTH;
          push_rsp(ring_bytes[(ring_tail + DEPTH - 1) % DEPTH], i == take - 1, 1'b0);
        end
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Response side
  // --------------------------------------------------------------------------

  // The receiver stalls at random, or solidly while a hold-off is running.
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  function automatic void check_field(input string name, input logic [OVF_W-1:0] want,
                                      input logic [OVF_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Inputs only change at the rising edge, so the values seen at the falling
  // edge are exactly the ones the next rising edge will act on.
  always @(negedge clk) begin : rsp_check
    fifo_rsp_t e;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (rsp_expect_q.size() == 0) begin
        $error("response with no request waiting for it: read_byte 0x%0h", read_byte);
        mismatches++;
      end else begin
        e = rsp_expect_q.pop_front();
        check_field("read_byte", OVF_W'(e.data), OVF_W'(read_byte));
        check_field("last_of_burst", OVF_W'(e.last), OVF_W'(last_of_burst));
        check_field("was_empty", OVF_W'(e.empty), OVF_W'(was_empty));
        check_field("fill_level", OVF_W'(e.fill), OVF_W'(fill_level));
        check_field("space_left", OVF_W'(e.room), OVF_W'(space_left));
        check_field("overflow_count", e.dropped, overflow_count);
        rsp_checked++;
        if (e.empty) begin
          empty_seen++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offers one request, possibly after some idle cycles, and holds it steady
  // until the block takes it. Valid stays high afterwards so back-to-back
  // requests go out without a gap.
  task automatic send_request(input req_kind_t kind, input logic [BYTE_W-1:0] d,
                              input logic [BURST_W-1:0] bl);
    bit taken;
    while ($urandom_range(99) < src_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid    <= 1'b1;
    req_type     <= kind;
    data_byte    <= d;
    burst_length <= bl;
    do begin
      @(negedge clk);
      taken = (req_stall === 1'b0);
      @(posedge clk);
    end while (!taken);
    predict_request(kind, d, bl);
    if (kind == REQ_WRITE) begin
      writes_sent++;
    end else begin
      reads_sent++;
    end
  endtask

  // The unused field of each request carries random bits, since the block
  // must ignore it.
  task automatic write_byte(input logic [BYTE_W-1:0] d);
    send_request(REQ_WRITE, d, BURST_W'($urandom_range(127)));
  endtask

  task automatic read_burst(input logic [BURST_W-1:0] bl);
    send_request(REQ_READ, BYTE_W'($urandom_range(255)), bl);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty reads, byte extremes, zero and oversized burst lengths, and bursts
  // that ask for more than is held.
  task automatic test_directed();
    src_idle_pct  = 28;
    sink_idle_pct = 53;
    read_burst(BURST_W'(1));
    read_burst(BURST_W'(0));
    write_byte(8'h00);
    write_byte(8'hFF);
    write_byte(8'hA5);
    write_byte(8'h5A);
    // A zero burst answers empty even though four bytes are held.
    read_burst(BURST_W'(0));
    read_burst(BURST_W'(2));
    // The longest encodable burst is clipped, then clipped again by the fill.
    read_burst(BURST_W'(127));
    read_burst(BURST_W'(1));
    write_byte(8'h80);
    write_byte(8'h7F);
    write_byte(8'h55);
    read_burst(BURST_W'(MAX_BURST + 1));
    write_byte(8'hC3);
    read_burst(BURST_W'(MAX_BURST));
    read_burst(BURST_W'(MAX_BURST));
  endtask

  // Writes past capacity so the oldest bytes get overwritten, then drains
  // the full ring in maximum-length bursts down to an empty read.
  task automatic test_overwrite();
    src_idle_pct  = 28;
    sink_idle_pct = 53;
    write_byte(8'h00);
    write_byte(8'hFF);
    repeat (258) begin
      write_byte(BYTE_W'($urandom_range(255)));
    end
    repeat (5) begin
      read_burst(BURST_W'(MAX_BURST));
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  // The first read burst parks in the output register and the block then
  // stalls its request side until the receiver lets go.
  task automatic test_backpressure();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_len = HOLD_CYCLES;
    hold_seq++;
    repeat (24) begin
      write_byte(BYTE_W'($urandom_range(255)));
    end
    read_burst(BURST_W'(16));
    read_burst(BURST_W'(16));
    repeat (4) begin
      write_byte(BYTE_W'($urandom_range(255)));
    end
    read_burst(BURST_W'(MAX_BURST));
    read_burst(BURST_W'(1));
  endtask

  // Runs of writes with random data, each followed by one read. Bursts are
  // mostly short so the ring keeps some fill, and now and then a burst
  // length is zero or oversized. Runs are cut so the total stays at n_items.
  task automatic test_random(input int src_pct, input int sink_pct, input int n_items);
    int sent;
    int run;
    int pick;
    logic [BURST_W-1:0] bl;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    sent = 0;
    while (sent < n_items) begin
      run = ($urandom_range(7) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 6);
      if (run > n_items - sent - 1) begin
        run = n_items - sent - 1;
      end
      repeat (run) begin
        write_byte(BYTE_W'($urandom_range(255)));
        sent++;
      end
      pick = $urandom_range(15);
      case (pick)
        0: begin
          bl = '0;
        end
        1: begin
          bl = BURST_W'($urandom_range(MAX_BURST + 1, 127));
        end
        2: begin
          bl = BURST_W'(MAX_BURST);
        end
        3, 4, 5: begin
          bl = BURST_W'($urandom_range(1, MAX_BURST));
        end
        default: begin
          bl = BURST_W'($urandom_range(1, 16));
        end
      endcase
      read_burst(bl);
      sent++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_overwrite();
    test_random(28, 53, 20);
    test_random(53, 28, 20);
    test_random(0, 0, 20);
    test_backpressure();

    req_valid <= 1'b0;
    while (rsp_expect_q.size() != 0) begin
      @(posedge clk);
    end
    // Any stray response after the last expected one is still caught here.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d writes and %0d read bursts; %0d responses checked, %0d empty.",
             writes_sent, reads_sent, rsp_checked, empty_seen);
    $display("%0d bytes were overwritten on a full ring, with one %0d-cycle response hold-off.",
             overwrites, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
